// ===== hw/rtl/fcsu_pkg.sv =====
// Shared constants and types for the four-channel sample unpacker.
`timescale 1ns / 1ps
`default_nettype none
package fcsu_pkg;

    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 4;
    localparam int SAMPLE_W    = 24;
    localparam int WIDTH_W     = 5;
    localparam int NUM_SAMPLES = 4;
    // largest code the header nibble can carry
    localparam int CODE_TOP    = 15;
    // stream bits that the largest code can address
    localparam int PAD_W       = CODE_TOP * BYTE_W;

    localparam logic [CODE_W-1:0] CODE_EMPTY = 4'h0;

    // group descriptor handed from the collector to the extractor
    typedef struct packed {
        logic              bad;
        logic [CODE_W-1:0] code;
    } t_grp_ctl;

    localparam int CTL_W = $bits(t_grp_ctl);

endpackage
`default_nettype wire

// ===== hw/rtl/fcsu_front.sv =====
// Byte collector: parses headers, gathers data bytes, pushes complete groups.
`timescale 1ns / 1ps
`default_nettype none
module fcsu_front #(
    parameter int MAX_CODE = 12
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  [fcsu_pkg::BYTE_W-1:0]           i_in_byte,
    input  wire                                   i_q_full,
    output logic                                  o_push,
    output fcsu_pkg::t_grp_ctl                    o_ctl,
    output logic [MAX_CODE*fcsu_pkg::BYTE_W-1:0]  o_stream
);

    localparam int IDX_W = (MAX_CODE > 1) ? $clog2(MAX_CODE) : 1;
    localparam logic [fcsu_pkg::CODE_W:0] MAX_CODE_V = (fcsu_pkg::CODE_W + 1)'(MAX_CODE);

    logic [fcsu_pkg::CODE_W-1:0] r_remain, n_remain;
    logic [fcsu_pkg::CODE_W-1:0] r_code, n_code;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [fcsu_pkg::BYTE_W-1:0] r_bytes [MAX_CODE];

    logic                        collecting;
    logic [fcsu_pkg::CODE_W-1:0] hdr_code;
    logic                        hdr_bad;
    logic                        complete;
    logic                        accept;

    assign collecting = (r_remain != '0);
    assign hdr_code   = i_in_byte[fcsu_pkg::CODE_W-1:0];
    assign hdr_bad    = ({1'b0, hdr_code} > MAX_CODE_V);
    assign complete   = collecting ? (r_remain == fcsu_pkg::CODE_W'(1))
                                   : ((hdr_code == fcsu_pkg::CODE_EMPTY) || hdr_bad);

    // header bytes and the byte that closes a group need queue space; other data bytes do not
    assign o_in_ready = !i_q_full || (collecting && (r_remain != fcsu_pkg::CODE_W'(1)));
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && complete;

    always_comb begin
        o_ctl.bad  = !collecting && hdr_bad;
        o_ctl.code = collecting ? r_code : fcsu_pkg::CODE_EMPTY;
        for (int j = 0; j < MAX_CODE; j++) begin
            if (collecting && (r_idx == IDX_W'(j))) begin
                o_stream[j*fcsu_pkg::BYTE_W +: fcsu_pkg::BYTE_W] = i_in_byte;
            end else begin
                o_stream[j*fcsu_pkg::BYTE_W +: fcsu_pkg::BYTE_W] = r_bytes[j];
            end
        end
    end

    always_comb begin
        n_remain = r_remain;
        n_code   = r_code;
        n_idx    = r_idx;
        if (accept) begin
            if (collecting) begin
                n_remain = r_remain - fcsu_pkg::CODE_W'(1);
                n_idx    = r_idx + IDX_W'(1);
            end else if (!hdr_bad && (hdr_code != fcsu_pkg::CODE_EMPTY)) begin
                n_remain = hdr_code;
                n_code   = hdr_code;
                n_idx    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= '0;
            r_code   <= '0;
            r_idx    <= '0;
        end else begin
            r_remain <= n_remain;
            r_code   <= n_code;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && collecting) begin
            r_bytes[r_idx] <= i_in_byte;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fcsu_queue.sv =====
// Two-entry queue of collected groups between collector and extractor.
`timescale 1ns / 1ps
`default_nettype none
module fcsu_queue #(
    parameter int DATA_W = 101
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    output logic              o_full,
    input  wire               i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr, n_wr_ptr;
    logic              r_rd_ptr, n_rd_ptr;
    logic [1:0]        r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fcsu_back.sv =====
// Sample extractor: slices four samples per group and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module fcsu_back #(
    parameter int MAX_CODE = 12
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_q_empty,
    input  fcsu_pkg::t_grp_ctl                    i_ctl,
    input  wire  [MAX_CODE*fcsu_pkg::BYTE_W-1:0]  i_stream,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic signed [fcsu_pkg::SAMPLE_W-1:0]  o_sample_a,
    output logic signed [fcsu_pkg::SAMPLE_W-1:0]  o_sample_b,
    output logic signed [fcsu_pkg::SAMPLE_W-1:0]  o_sample_c,
    output logic signed [fcsu_pkg::SAMPLE_W-1:0]  o_sample_d,
    output logic [fcsu_pkg::WIDTH_W-1:0]          o_sample_width,
    output logic                                  o_bad_header
);

    localparam int STREAM_W = MAX_CODE * fcsu_pkg::BYTE_W;
    localparam int SW       = fcsu_pkg::SAMPLE_W;

    logic [fcsu_pkg::PAD_W-1:0] pad;
    logic [SW-1:0]              cand [fcsu_pkg::CODE_TOP+1][fcsu_pkg::NUM_SAMPLES];
    logic [SW-1:0]              sel  [fcsu_pkg::NUM_SAMPLES];

    logic                       r_valid;
    logic [SW-1:0]              r_smp [fcsu_pkg::NUM_SAMPLES];
    logic [fcsu_pkg::WIDTH_W-1:0] r_width;
    logic                       r_bad;

    generate
        if (STREAM_W < fcsu_pkg::PAD_W) begin : g_pad
            assign pad = {{(fcsu_pkg::PAD_W - STREAM_W){1'b0}}, i_stream};
        end else begin : g_trim
            assign pad = i_stream[fcsu_pkg::PAD_W-1:0];
        end
    endgenerate

    // one fixed slice per (code, sample); code 0 stands for empty or bad groups
    generate
        for (genvar k = 0; k < fcsu_pkg::NUM_SAMPLES; k++) begin : g_smp
            assign cand[0][k] = '0;
            for (genvar c = 1; c <= fcsu_pkg::CODE_TOP; c++) begin : g_code
                if (2 * c < SW) begin : g_ext
                    assign cand[c][k] = {{(SW - 2*c){pad[k*2*c + 2*c - 1]}},
                                         pad[k*2*c +: 2*c]};
                end else begin : g_cut
                    assign cand[c][k] = pad[k*2*c +: SW];
                end
            end
            assign sel[k] = cand[i_ctl.code][k];
        end
    endgenerate

    assign o_pop       = !i_q_empty && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < fcsu_pkg::NUM_SAMPLES; k++) begin
                r_smp[k] <= sel[k];
            end
            r_width <= {i_ctl.code, 1'b0};
            r_bad   <= i_ctl.bad;
        end
    end

    assign o_sample_a     = r_smp[0];
    assign o_sample_b     = r_smp[1];
    assign o_sample_c     = r_smp[2];
    assign o_sample_d     = r_smp[3];
    assign o_sample_width = r_width;
    assign o_bad_header   = r_bad;

endmodule
`default_nettype wire

// ===== hw/rtl/four_channel_sample_unpacker_core.sv =====
// Path: the transaction carrying a group's last byte pushes it into the queue (the header
// itself for empty or bad groups); the extractor then pops it into the output register.
// Throughput: one byte per cycle while the group queue has room; a valid group of code c
// takes c+1 byte transactions and a bad header takes one, set by the single byte port; a
// 2-entry group queue plus output register decouple stalls.
// Reset: synchronous, active low, clears parser, queue control and output valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module four_channel_sample_unpacker_core #(
    parameter int MAX_SAMPLE_BITS = 24
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  [fcsu_pkg::BYTE_W-1:0]          i_in_byte,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [fcsu_pkg::SAMPLE_W-1:0] o_sample_a,
    output logic signed [fcsu_pkg::SAMPLE_W-1:0] o_sample_b,
    output logic signed [fcsu_pkg::SAMPLE_W-1:0] o_sample_c,
    output logic signed [fcsu_pkg::SAMPLE_W-1:0] o_sample_d,
    output logic [fcsu_pkg::WIDTH_W-1:0]         o_sample_width,
    output logic                                 o_bad_header
);

    localparam int MAX_CODE = MAX_SAMPLE_BITS / 2;
    localparam int STREAM_W = MAX_CODE * fcsu_pkg::BYTE_W;
    localparam int REC_W    = STREAM_W + fcsu_pkg::CTL_W;

    logic                   q_full;
    logic                   q_empty;
    logic                   push;
    logic                   pop;
    fcsu_pkg::t_grp_ctl     push_ctl;
    fcsu_pkg::t_grp_ctl     head_ctl;
    logic [STREAM_W-1:0]    push_stream;
    logic [STREAM_W-1:0]    head_stream;
    logic [REC_W-1:0]       head_rec;

    fcsu_front #(
        .MAX_CODE (MAX_CODE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_ctl      (push_ctl),
        .o_stream   (push_stream)
    );

    fcsu_queue #(
        .DATA_W (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_ctl, push_stream}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (head_rec),
        .o_empty (q_empty)
    );

    assign head_ctl    = fcsu_pkg::t_grp_ctl'(head_rec[REC_W-1 -: fcsu_pkg::CTL_W]);
    assign head_stream = head_rec[STREAM_W-1:0];

    fcsu_back #(
        .MAX_CODE (MAX_CODE)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_ctl          (head_ctl),
        .i_stream       (head_stream),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_a     (o_sample_a),
        .o_sample_b     (o_sample_b),
        .o_sample_c     (o_sample_c),
        .o_sample_d     (o_sample_d),
        .o_sample_width (o_sample_width),
        .o_bad_header   (o_bad_header)
    );

endmodule
`default_nettype wire

// ===== dv/fcsu_scoreboard.sv =====
// Checker for the sample unpacker: predicts each group result and compares it.
`timescale 1ns / 1ps
module fcsu_scoreboard (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    input  wire                                  i_in_ready,
    input  wire [fcsu_pkg::BYTE_W-1:0]           i_in_byte,
    input  wire                                  i_out_valid,
    input  wire                                  i_out_ready,
    input  wire [fcsu_pkg::SAMPLE_W-1:0]         i_sample_a,
    input  wire [fcsu_pkg::SAMPLE_W-1:0]         i_sample_b,
    input  wire [fcsu_pkg::SAMPLE_W-1:0]         i_sample_c,
    input  wire [fcsu_pkg::SAMPLE_W-1:0]         i_sample_d,
    input  wire [fcsu_pkg::WIDTH_W-1:0]          i_sample_width,
    input  wire                                  i_bad_header,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    // widest legal code for 24-bit samples
    localparam int MAX_CODE = 12;
    localparam int STREAM_W = MAX_CODE * fcsu_pkg::BYTE_W;

    typedef struct packed {
        logic [fcsu_pkg::NUM_SAMPLES-1:0][fcsu_pkg::SAMPLE_W-1:0] smp;
        logic [fcsu_pkg::WIDTH_W-1:0]                             width;
        logic                                                     bad;
    } t_group_result;

    logic [fcsu_pkg::CODE_W-1:0] bytes_left;
    logic [fcsu_pkg::CODE_W-1:0] grp_code;
    logic [fcsu_pkg::BYTE_W-1:0] grp_bytes [MAX_CODE];
    t_group_result               expected_groups [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // sample k of width w from the collected bytes, sign-extended to 24 bits
    function automatic logic [fcsu_pkg::SAMPLE_W-1:0] unpack_sample(input int k, input int w);
        logic [STREAM_W-1:0]           bits;
        logic [fcsu_pkg::SAMPLE_W-1:0] v;
        for (int i = 0; i < MAX_CODE; i++) begin
            bits[i*fcsu_pkg::BYTE_W +: fcsu_pkg::BYTE_W] = grp_bytes[i];
        end
        for (int i = 0; i < fcsu_pkg::SAMPLE_W; i++) begin
            v[i] = (i < w) ? bits[k*w + i] : bits[k*w + w - 1];
        end
        return v;
    endfunction

    function automatic t_group_result make_result(input int w, input logic bad);
        t_group_result r;
        for (int k = 0; k < fcsu_pkg::NUM_SAMPLES; k++) begin
            r.smp[k] = (bad || w == 0) ? '0 : unpack_sample(k, w);
        end
        r.width = bad ? '0 : fcsu_pkg::WIDTH_W'(w);
        r.bad   = bad;
        return r;
    endfunction

    task automatic check_field(input string name,
                               input logic [fcsu_pkg::SAMPLE_W-1:0] exp_v,
                               input logic [fcsu_pkg::SAMPLE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_group_result               exp_r;
        logic [fcsu_pkg::CODE_W-1:0] code;
        if (!i_rst_n) begin
            bytes_left = '0;
            grp_code   = '0;
            expected_groups.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_groups.size() == 0) begin
                    $error("unexpected result transaction: width %0d bad %b",
                           i_sample_width, i_bad_header);
                    o_fail_count++;
                end else begin
                    exp_r = expected_groups.pop_front();
                    check_field("sample_a", exp_r.smp[0], i_sample_a);
                    check_field("sample_b", exp_r.smp[1], i_sample_b);
                    check_field("sample_c", exp_r.smp[2], i_sample_c);
                    check_field("sample_d", exp_r.smp[3], i_sample_d);
                    check_field("sample_width", fcsu_pkg::SAMPLE_W'(exp_r.width),
                                fcsu_pkg::SAMPLE_W'(i_sample_width));
                    check_field("bad_header", fcsu_pkg::SAMPLE_W'(exp_r.bad),
                                fcsu_pkg::SAMPLE_W'(i_bad_header));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (bytes_left == 0) begin
                    // header: low nibble only
                    code = i_in_byte[fcsu_pkg::CODE_W-1:0];
                    if (code > MAX_CODE) begin
                        expected_groups.push_back(make_result(0, 1'b1));
                    end else if (code == fcsu_pkg::CODE_EMPTY) begin
                        grp_code = fcsu_pkg::CODE_EMPTY;
                        expected_groups.push_back(make_result(0, 1'b0));
                    end else begin
                        grp_code   = code;
                        bytes_left = code;
                    end
                end else begin
                    grp_bytes[grp_code - bytes_left] = i_in_byte;
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == 0) begin
                        expected_groups.push_back(make_result(2 * grp_code, 1'b0));
                    end
                end
            end
        end
        o_pending = expected_groups.size();
    end

endmodule

// ===== dv/four_channel_sample_unpacker_core_tb.sv =====
// Testbench top for the sample unpacker: byte stimulus, flow control and verdict.
`timescale 1ns / 1ps
module four_channel_sample_unpacker_core_tb;

    localparam int MAX_CODE       = 12;
    localparam int BAD_CODE_LO    = MAX_CODE + 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 520;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic [fcsu_pkg::BYTE_W-1:0]   i_in_byte      = '0;
    logic                          i_out_ready    = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [fcsu_pkg::SAMPLE_W-1:0] o_sample_a;
    logic [fcsu_pkg::SAMPLE_W-1:0] o_sample_b;
    logic [fcsu_pkg::SAMPLE_W-1:0] o_sample_c;
    logic [fcsu_pkg::SAMPLE_W-1:0] o_sample_d;
    logic [fcsu_pkg::WIDTH_W-1:0]  o_sample_width;
    logic                          o_bad_header;

    int fail_count;
    int pending;
    int send_idle   = 0;
    int recv_idle   = 0;
    int items_sent  = 0;
    int idle_cycles = 0;

    four_channel_sample_unpacker_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_a     (o_sample_a),
        .o_sample_b     (o_sample_b),
        .o_sample_c     (o_sample_c),
        .o_sample_d     (o_sample_d),
        .o_sample_width (o_sample_width),
        .o_bad_header   (o_bad_header)
    );

    fcsu_scoreboard u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_sample_a     (o_sample_a),
        .i_sample_b     (o_sample_b),
        .i_sample_c     (o_sample_c),
        .i_sample_d     (o_sample_d),
        .i_sample_width (o_sample_width),
        .i_bad_header   (o_bad_header),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // ends the run when neither channel moves a transaction for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [fcsu_pkg::BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [fcsu_pkg::BYTE_W-1:0] pick_data();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return fcsu_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_random_group();
        int kind;
        logic [fcsu_pkg::CODE_W-1:0] code;
        logic [fcsu_pkg::CODE_W-1:0] hi;
        kind = $urandom_range(0, 99);
        hi   = fcsu_pkg::CODE_W'($urandom_range(0, 15));
        if (kind < 6) begin
            code = fcsu_pkg::CODE_EMPTY;
        end else if (kind < 12) begin
            code = fcsu_pkg::CODE_W'($urandom_range(BAD_CODE_LO, fcsu_pkg::CODE_TOP));
        end else if (kind < 22) begin
            code = fcsu_pkg::CODE_W'(MAX_CODE);
        end else begin
            code = fcsu_pkg::CODE_W'($urandom_range(1, MAX_CODE));
        end
        send_byte({hi, code});
        for (int i = 0; i < code; i++) begin
            send_byte(pick_data());
        end
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct);
        int start_cnt;
        send_idle = s_pct;
        recv_idle = r_pct;
        start_cnt = items_sent;
        while (items_sent - start_cnt < PHASE_ITEMS) begin
            send_random_group();
        end
        // hold the sender off until every result is back
        i_in_valid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle = 13;
        recv_idle = 50;
        // empty groups, high nibble ignored, every bad code
        send_byte({4'h0, fcsu_pkg::CODE_EMPTY});
        send_byte({4'hF, fcsu_pkg::CODE_EMPTY});
        send_byte(8'h0D);
        send_byte(8'hEE);
        send_byte(8'h0F);
        // narrowest width: all ones (-1) and all zeros
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'hF1);
        send_byte(8'h00);
        // widest width: max positive, min negative, -1, zero
        send_byte(8'h0C);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        i_in_valid <= 1'b0;
        wait_drained();

        run_phase(13, 50);
        run_phase(50, 13);
        run_phase(0, 0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/fcsu_pkg.sv
hw/rtl/fcsu_front.sv
hw/rtl/fcsu_queue.sv
hw/rtl/fcsu_back.sv
hw/rtl/four_channel_sample_unpacker_core.sv
dv/fcsu_scoreboard.sv
dv/four_channel_sample_unpacker_core_tb.sv
